/* hdl/stp_pkg.sv */
// ----------------------------------------------------------------------------
// Section time profiler package
// Shared widths, default sizes, command codes and sequencer states.
// ----------------------------------------------------------------------------
package stp_pkg;

   localparam int SECTIONS_DEFAULT      = 11;
   localparam int HISTORY_DEPTH_DEFAULT = 256;

   localparam int TICK_W = 32;   // timestamps, accumulators, last-frame times
   localparam int AVG_W  = 40;   // moving average, 8 fraction bits
   localparam int CMD_W  = 3;
   localparam int SEC_W  = 4;
   localparam int HIDX_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN = 3'd0,
      CMD_END   = 3'd1,
      CMD_ADD   = 3'd2,
      CMD_FRAME = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FRAME,
      ST_WRAP
   } state_type;

endpackage

/* hdl/stp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module stp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/stp_ema_unit.sv */
// ----------------------------------------------------------------------------
// Moving-average update unit
// Computes (avg*243 + accum*13*256) >> 8 with saturation to the average width.
// ----------------------------------------------------------------------------
module stp_ema_unit
   import stp_pkg::*;
(
   input  logic [AVG_W-1:0]  avg_i,
   input  logic [TICK_W-1:0] acc_i,
   output logic [AVG_W-1:0]  avg_o
);

   localparam int AvgWeight = 243;
   localparam int AccWeight = 13 * 256;
   localparam int FracBits  = 8;
   localparam int SumW      = AVG_W + FracBits + 1;

   logic [SumW-1:0]         sum;
   logic [SumW-FracBits-1:0] shifted;

   // Both products are by constants, so they reduce to a handful of adders.
   assign sum     = SumW'(avg_i) * SumW'(AvgWeight) + SumW'(acc_i) * SumW'(AccWeight);
   assign shifted = sum[SumW-1:FracBits];
   assign avg_o   = shifted[AVG_W] ? {AVG_W{1'b1}} : shifted[AVG_W-1:0];

endmodule

/* hdl/section_time_profiler_core.sv */
// ----------------------------------------------------------------------------
// Section time profiler core
// Per-section tick accumulators with frame close, moving average and history.
// ----------------------------------------------------------------------------
// Usage: each request beat carries a command (begin, end, add, end_frame,
// read), a section, a timestamp, an amount and a history index. Every
// request beat produces exactly one response beat; only read returns
// non-zero fields (last frame time, moving average, history entry, ring
// position). Unused command codes and out-of-range sections change nothing.
// Begin, end, add and read are registered, run in the exec state and give
// a registered response. end_frame walks all sections through the shared
// moving-average unit, one section per cycle, then writes the history
// ring and gives its response. One request is in flight at a time: no new
// request is taken before the previous one is back in the idle state.
// A new request may be taken while the previous response is being taken.
// Reset clears all section stores, the ring position and the history fill
// count at once; history entries beyond the fill count read as zero, so no
// clearing pass is needed. While rsp_stall is high the response holds and
// req_stall stays high until it is taken.
// ----------------------------------------------------------------------------
module section_time_profiler_core
   import stp_pkg::*;
#(
   parameter int SECTIONS      = SECTIONS_DEFAULT,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [SEC_W-1:0]  req_section,
   input  logic [TICK_W-1:0] req_timestamp,
   input  logic [TICK_W-1:0] req_amount,
   input  logic [HIDX_W-1:0] req_history_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [TICK_W-1:0] rsp_section_last,
   output logic [AVG_W-1:0]  rsp_section_avg,
   output logic [TICK_W-1:0] rsp_history_value,
   output logic [HIDX_W-1:0] rsp_history_pos
);

   localparam int SecIdxW  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int HistIdxW = $clog2(HISTORY_DEPTH);
   localparam int FillW    = $clog2(HISTORY_DEPTH + 1);

   state_type state_ff, state_in;

   logic [TICK_W-1:0] start_ff [SECTIONS];
   logic [TICK_W-1:0] acc_ff   [SECTIONS];
   logic [TICK_W-1:0] last_ff  [SECTIONS];
   logic [AVG_W-1:0]  avg_ff   [SECTIONS];

   logic [CMD_W-1:0]  cmd_ff;
   logic [SEC_W-1:0]  sec_ff;
   logic [TICK_W-1:0] ts_ff;
   logic [TICK_W-1:0] amt_ff;
   logic [HIDX_W-1:0] hidx_ff;

   logic [SecIdxW-1:0] iter_ff, iter_in;
   logic [HIDX_W-1:0]  pos_ff, pos_in;
   logic [FillW-1:0]   fill_ff, fill_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;
   logic [TICK_W-1:0] rsp_last_ff, rsp_last_in;
   logic [AVG_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [TICK_W-1:0] rsp_hist_ff, rsp_hist_in;
   logic [HIDX_W-1:0] rsp_pos_ff, rsp_pos_in;

   logic               req_accept;
   logic               sec_ok;
   logic [SecIdxW-1:0] sec_idx;
   logic [TICK_W-1:0]  elapsed;
   logic [TICK_W-1:0]  addend;
   logic [TICK_W:0]    acc_sum_wide;
   logic [TICK_W-1:0]  acc_sum;
   logic               start_we, acc_we, frame_we, ring_we;
   logic [AVG_W-1:0]   ema_out;
   logic [TICK_W-1:0]  ram_rdata;
   logic               hist_valid;
   logic [HIDX_W:0]    pos_inc;

   // ---------------------------------------------------------------- handshake
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------- datapath terms
   assign sec_ok       = 5'(sec_ff) < 5'(SECTIONS);
   assign sec_idx      = sec_ff[SecIdxW-1:0];
   assign elapsed      = ts_ff - start_ff[sec_idx];
   assign addend       = (cmd_ff == CMD_END) ? elapsed : amt_ff;
   assign acc_sum_wide = {1'b0, acc_ff[sec_idx]} + {1'b0, addend};
   assign acc_sum      = acc_sum_wide[TICK_W] ? {TICK_W{1'b1}} : acc_sum_wide[TICK_W-1:0];
   assign hist_valid   = 9'(hidx_ff) < 9'(fill_ff);
   assign pos_inc      = {1'b0, pos_ff} + 9'd1;

   stp_ema_unit u_ema (
      .avg_i (avg_ff[iter_ff]),
      .acc_i (acc_ff[iter_ff]),
      .avg_o (ema_out)
   );

   stp_ram #(
      .WIDTH (TICK_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (pos_ff[HistIdxW-1:0]),
      .wr_data (last_ff[0]),
      .rd_en   (req_accept),
      .rd_addr (req_history_index[HistIdxW-1:0]),
      .rd_data (ram_rdata)
   );

   // --------------------------------------------------------------- sequencer
   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      pos_in      = pos_ff;
      fill_in     = fill_ff;
      start_we    = 1'b0;
      acc_we      = 1'b0;
      frame_we    = 1'b0;
      ring_we     = 1'b0;
      rsp_load    = 1'b0;
      rsp_last_in = '0;
      rsp_avg_in  = '0;
      rsp_hist_in = '0;
      rsp_pos_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            iter_in = '0;
            if (req_accept) begin
               state_in = (req_cmd == CMD_FRAME) ? ST_FRAME : ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
            case (cmd_ff)
               CMD_BEGIN: start_we = sec_ok;
               CMD_END, CMD_ADD: acc_we = sec_ok;
               CMD_READ: begin
                  if (sec_ok) begin
                     rsp_last_in = last_ff[sec_idx];
                     rsp_avg_in  = avg_ff[sec_idx];
                  end
                  if (hist_valid) begin
                     rsp_hist_in = ram_rdata;
                  end
                  rsp_pos_in = pos_ff;
               end
               default: ;
            endcase
         end
         ST_FRAME: begin
            frame_we = 1'b1;
            iter_in  = iter_ff + 1'b1;
            if (iter_ff == SecIdxW'(SECTIONS - 1)) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            // Section 0 has already been closed, so its new last time is stored.
            ring_we  = 1'b1;
            rsp_load = 1'b1;
            state_in = ST_IDLE;
            pos_in   = (pos_inc >= 9'(HISTORY_DEPTH)) ? '0 : pos_inc[HIDX_W-1:0];
            if (fill_ff < FillW'(HISTORY_DEPTH)) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // --------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '{default: '0};
         acc_ff   <= '{default: '0};
         last_ff  <= '{default: '0};
         avg_ff   <= '{default: '0};
      end else begin
         if (start_we) begin
            start_ff[sec_idx] <= ts_ff;
         end
         if (acc_we) begin
            acc_ff[sec_idx] <= acc_sum;
         end
         if (frame_we) begin
            avg_ff[iter_ff]  <= ema_out;
            last_ff[iter_ff] <= acc_ff[iter_ff];
            acc_ff[iter_ff]  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_cmd;
         sec_ff  <= req_section;
         ts_ff   <= req_timestamp;
         amt_ff  <= req_amount;
         hidx_ff <= req_history_index;
      end
      if (rsp_load) begin
         rsp_last_ff <= rsp_last_in;
         rsp_avg_ff  <= rsp_avg_in;
         rsp_hist_ff <= rsp_hist_in;
         rsp_pos_ff  <= rsp_pos_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_section_last  = rsp_last_ff;
   assign rsp_section_avg   = rsp_avg_ff;
   assign rsp_history_value = rsp_hist_ff;
   assign rsp_history_pos   = rsp_pos_ff;

   // -------------------------------------------------------------- assertions
`ifndef SYNTHESIS
   a_frame_to_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRAME && iter_ff == SecIdxW'(SECTIONS - 1)) |=> state_ff == ST_WRAP)
      else $error("frame walk did not finish after the last section");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC || state_ff == ST_WRAP) |-> !rsp_valid_ff)
      else $error("response loaded while the previous one is still held");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_WRAP))
      else $error("response appeared without a finished request");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (9'(fill_ff) <= 9'(HISTORY_DEPTH)) && (9'(pos_ff) < 9'(HISTORY_DEPTH)))
      else $error("history fill count or ring position out of range");
`endif

endmodule

/* test/section_time_profiler_core_tb.sv */
// ----------------------------------------------------------------------------
// Section time profiler core testbench
// Drives begin, end, add, end_frame, read and unused-code requests with random
// gaps on the request side and random back-pressure on the response side. A
// scoreboard keeps its own copy of the section stores and the history ring,
// predicts every response and compares each returned beat against the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module section_time_profiler_core_tb;
   import stp_pkg::*;

   localparam int N_SEC       = SECTIONS_DEFAULT;
   localparam int HIST_DEPTH  = HISTORY_DEPTH_DEFAULT;
   localparam int SEC_MAX     = (1 << SEC_W) - 1;
   localparam int RANDOM_BEATS = 850;
   localparam int DRAIN_CYCLES = N_SEC + 10;

   localparam logic [CMD_W-1:0]  CMD_SPARE_LO = CMD_READ + 1'b1;
   localparam logic [CMD_W-1:0]  CMD_SPARE_HI = '1;
   localparam logic [TICK_W-1:0] TICK_MAX     = '1;
   localparam logic [AVG_W-1:0]  AVG_MAX      = '1;
   localparam logic [HIDX_W-1:0] HIDX_MAX     = '1;

   typedef struct packed {
      logic [TICK_W-1:0] section_last;
      logic [AVG_W-1:0]  section_avg;
      logic [TICK_W-1:0] history_value;
      logic [HIDX_W-1:0] history_pos;
   } profile_report_type;

   class profile_scoreboard_type;
      logic [TICK_W-1:0]  start_time [N_SEC];
      logic [TICK_W-1:0]  accum      [N_SEC];
      logic [TICK_W-1:0]  last_frame [N_SEC];
      logic [AVG_W-1:0]   moving_avg [N_SEC];
      logic [TICK_W-1:0]  history    [HIST_DEPTH];
      logic [HIDX_W-1:0]  ring_pos;
      profile_report_type expected_q[$];
      int                 mismatches;

      function new();
         for (int i = 0; i < N_SEC; i++) begin
            start_time[i] = '0;
            accum[i]      = '0;
            last_frame[i] = '0;
            moving_avg[i] = '0;
         end
         for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
         ring_pos   = '0;
         mismatches = 0;
      endfunction

      function logic [TICK_W-1:0] saturating_add(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b);
         logic [TICK_W:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
      endfunction

      // Closes a frame: latch, average and clear every section, then log
      // section 0 into the history ring.
      function void close_frame();
         logic [63:0] blend;
         for (int i = 0; i < N_SEC; i++) begin
            blend = 64'(moving_avg[i]) * 64'd243 + 64'(accum[i]) * 64'd3328;
            blend = blend >> 8;
            moving_avg[i] = (blend > 64'(AVG_MAX)) ? AVG_MAX : blend[AVG_W-1:0];
            last_frame[i] = accum[i];
            accum[i]      = '0;
         end
         if (int'(ring_pos) < HIST_DEPTH) history[ring_pos] = last_frame[0];
         if (int'(ring_pos) + 1 >= HIST_DEPTH) ring_pos = '0;
         else ring_pos = ring_pos + 1'b1;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [SEC_W-1:0] sec,
                                 logic [TICK_W-1:0] ts, logic [TICK_W-1:0] amt,
                                 logic [HIDX_W-1:0] hidx);
         profile_report_type rep;
         bit                 sec_ok;
         rep    = '0;
         sec_ok = int'(sec) < N_SEC;
         case (cmd)
            CMD_BEGIN: if (sec_ok) start_time[sec] = ts;
            CMD_END: if (sec_ok) accum[sec] = saturating_add(accum[sec], ts - start_time[sec]);
            CMD_ADD: if (sec_ok) accum[sec] = saturating_add(accum[sec], amt);
            CMD_FRAME: close_frame();
            CMD_READ: begin
               if (sec_ok) begin
                  rep.section_last = last_frame[sec];
                  rep.section_avg  = moving_avg[sec];
               end
               if (int'(hidx) < HIST_DEPTH) rep.history_value = history[hidx];
               rep.history_pos = ring_pos;
            end
            default: ;
         endcase
         expected_q.push_back(rep);
      endfunction

      function void check_response(profile_report_type got);
         profile_report_type exp_rep;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response beat with nothing expected: last=%h avg=%h hist=%h pos=%h",
                        got.section_last, got.section_avg, got.history_value, got.history_pos);
            return;
         end
         exp_rep = expected_q.pop_front();
         if (got.section_last !== exp_rep.section_last ||
             got.section_avg !== exp_rep.section_avg ||
             got.history_value !== exp_rep.history_value ||
             got.history_pos !== exp_rep.history_pos) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch at %0t: expected %h %h %h %h, got %h %h %h %h",
                        $realtime, exp_rep.section_last, exp_rep.section_avg,
                        exp_rep.history_value, exp_rep.history_pos, got.section_last,
                        got.section_avg, got.history_value, got.history_pos);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [CMD_W-1:0]  req_cmd;
   logic [SEC_W-1:0]  req_section;
   logic [TICK_W-1:0] req_timestamp;
   logic [TICK_W-1:0] req_amount;
   logic [HIDX_W-1:0] req_history_index;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [TICK_W-1:0] rsp_section_last;
   logic [AVG_W-1:0]  rsp_section_avg;
   logic [TICK_W-1:0] rsp_history_value;
   logic [HIDX_W-1:0] rsp_history_pos;

   profile_scoreboard_type sb = new();
   bit                     quiet_stretch = 1'b0;
   int                     beats_sent = 0;

   section_time_profiler_core #(
      .SECTIONS      (N_SEC),
      .HISTORY_DEPTH (HIST_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_section       (req_section),
      .req_timestamp     (req_timestamp),
      .req_amount        (req_amount),
      .req_history_index (req_history_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_section_last  (rsp_section_last),
      .rsp_section_avg   (rsp_section_avg),
      .rsp_history_value (rsp_history_value),
      .rsp_history_pos   (rsp_history_pos)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int idle_cycles();
      return quiet_stretch ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic logic [SEC_W-1:0] pick_section();
      if ($urandom_range(0, 99) < 88) return SEC_W'($urandom_range(0, N_SEC - 1));
      return SEC_W'($urandom_range(N_SEC, SEC_MAX));
   endfunction

   function automatic logic [TICK_W-1:0] pick_amount();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return TICK_W'($urandom_range(0, 100000));
      if (roll < 95) return TICK_W'($urandom);
      return TICK_MAX;
   endfunction

   // Presents one request beat after a random gap and holds it until taken.
   task automatic send_beat(logic [CMD_W-1:0] cmd, logic [SEC_W-1:0] sec,
                            logic [TICK_W-1:0] ts, logic [TICK_W-1:0] amt,
                            logic [HIDX_W-1:0] hidx);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_section       <= sec;
      req_timestamp     <= ts;
      req_amount        <= amt;
      req_history_index <= hidx;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, sec, ts, amt, hidx);
      beats_sent++;
      if ($urandom_range(0, 39) == 0) quiet_stretch = !quiet_stretch;
   endtask

   task automatic send_random_group();
      logic [TICK_W-1:0] t0;
      logic [TICK_W-1:0] delta;
      logic [SEC_W-1:0]  sec;
      int                roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
         // Well-formed begin/end pair, occasionally closed on another section.
         sec = pick_section();
         t0  = $urandom;
         send_beat(CMD_BEGIN, sec, t0, $urandom, HIDX_W'($urandom));
         delta = ($urandom_range(0, 9) < 7) ? TICK_W'($urandom_range(0, 5000)) : $urandom;
         if ($urandom_range(0, 9) == 0) sec = pick_section();
         send_beat(CMD_END, sec, t0 + delta, $urandom, HIDX_W'($urandom));
      end else if (roll < 35) begin
         send_beat(CMD_ADD, pick_section(), $urandom, pick_amount(), HIDX_W'($urandom));
      end else if (roll < 75) begin
         send_beat(CMD_FRAME, SEC_W'($urandom), $urandom, $urandom, HIDX_W'($urandom));
      end else if (roll < 97) begin
         send_beat(CMD_READ, pick_section(), $urandom, $urandom, HIDX_W'($urandom));
      end else if (roll < 99) begin
         send_beat(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), SEC_W'($urandom),
                   $urandom, $urandom, HIDX_W'($urandom));
      end else begin
         send_beat(CMD_END, pick_section(), $urandom, $urandom, HIDX_W'($urandom));
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_cmd           <= CMD_BEGIN;
      req_section       <= '0;
      req_timestamp     <= '0;
      req_amount        <= '0;
      req_history_index <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reset state, wrap, saturation, ignored beats.
      send_beat(CMD_READ, '0, '0, '0, '0);
      send_beat(CMD_END, 4'd1, 32'd1000, '0, '0);
      send_beat(CMD_BEGIN, '0, 32'hFFFF_FFF0, '0, '0);
      send_beat(CMD_END, '0, 32'h0000_0010, '0, '0);
      send_beat(CMD_ADD, 4'd2, '0, TICK_MAX, '0);
      send_beat(CMD_ADD, 4'd2, '0, 32'd5, '0);
      send_beat(CMD_ADD, 4'd10, TICK_MAX, TICK_MAX, HIDX_MAX);
      send_beat(CMD_BEGIN, SEC_W'(SEC_MAX), TICK_MAX, TICK_MAX, HIDX_MAX);
      send_beat(CMD_END, SEC_W'(N_SEC), TICK_MAX, '0, '0);
      send_beat(CMD_ADD, SEC_W'(N_SEC + 1), '0, TICK_MAX, '0);
      send_beat(CMD_SPARE_LO, 4'd3, TICK_MAX, TICK_MAX, HIDX_MAX);
      send_beat(CMD_SPARE_LO + 1'b1, 4'd3, '0, '0, '0);
      send_beat(CMD_SPARE_HI, SEC_W'(SEC_MAX), TICK_MAX, TICK_MAX, HIDX_MAX);
      send_beat(CMD_FRAME, SEC_W'(SEC_MAX), TICK_MAX, TICK_MAX, HIDX_MAX);
      send_beat(CMD_READ, '0, '0, '0, '0);
      send_beat(CMD_READ, 4'd1, '0, '0, 8'd1);
      send_beat(CMD_READ, 4'd2, '0, '0, HIDX_MAX);
      send_beat(CMD_READ, 4'd10, TICK_MAX, TICK_MAX, '0);
      send_beat(CMD_READ, SEC_W'(SEC_MAX), '0, '0, 8'd1);
      send_beat(CMD_ADD, 4'd10, '0, TICK_MAX, '0);
      send_beat(CMD_FRAME, '0, '0, '0, '0);
      send_beat(CMD_FRAME, '0, '0, '0, '0);
      send_beat(CMD_READ, 4'd10, '0, '0, 8'd2);

      while (beats_sent < 23 + RANDOM_BEATS) send_random_group();
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Response side: a random stall before each beat, then take it.
   initial begin
      int hold;
      profile_report_type got;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = idle_cycles();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.section_last  = rsp_section_last;
         got.section_avg   = rsp_section_avg;
         got.history_value = rsp_history_value;
         got.history_pos   = rsp_history_pos;
         sb.check_response(got);
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
